>>> rtl/mbrs_pkg.sv
// Shared types, constants and CRC helper for the Modbus RTU slave register map.
package mbrs_pkg;

  localparam int unsigned REG_DEPTH_DEF   = 1024;
  localparam int unsigned FRAME_BYTES_DEF = 256;
  localparam int unsigned MAX_READ_DEF    = 125;

  localparam int unsigned OFF_W = 9;
  localparam int unsigned CNT_W = 7;

  localparam logic [7:0] FN_READ   = 8'h03;
  localparam logic [7:0] FN_WRITE1 = 8'h06;
  localparam logic [7:0] FN_WRITEN = 8'h10;
  localparam logic [7:0] EXC_FLAG  = 8'h80;
  localparam logic [7:0] EXC_ADDR  = 8'h03;

  localparam logic [OFF_W-1:0] NEED_FIXED = 9'h008;
  localparam logic [OFF_W-1:0] NEED_BASE  = 9'h009;
  localparam logic [OFF_W-1:0] FILL_MIN   = 9'h004;
  localparam logic [OFF_W-1:0] FILL_MULTI = 9'h007;
  localparam logic [OFF_W-1:0] OFF_FN     = 9'h001;
  localparam logic [OFF_W-1:0] OFF_CNT    = 9'h006;
  localparam logic [OFF_W-1:0] OFF_DATA   = 9'h007;
  localparam logic [OFF_W-1:0] HDR_SHORT  = 9'h003;
  localparam logic [OFF_W-1:0] HDR_ECHO   = 9'h006;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [2:0] {
    RS_FN, RS_B6, RS_ZERO, RS_NEXT, RS_WHI, RS_WLO
  } rsel_e;

  typedef enum logic [2:0] {
    PS_HDR, PS_RHI, PS_RLO, PS_CRCL, PS_CRCH
  } psrc_e;

  typedef struct packed {
    logic  clr;
    logic  append;
    logic  rd_en;
    rsel_e rsel;
    logic  set_need8;
    logic  lat_need;
    logic  drop1;
    logic  drop_need;
    logic  crc_init;
    logic  crc_step;
    logic  rsp_init;
    logic  push;
    psrc_e psrc;
    logic  reg_rd;
    logic  i_inc;
    logic  lat_hi;
    logic  wr_one;
    logic  wr_multi;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic fill_le4;
    logic fill_lt7;
    logic fn_fixed;
    logic fn_multi;
    logic need_big;
    logic fill_lt_need;
    logic crc_last;
    logic crc_good;
    logic is_read;
    logic is_write1;
    logic is_mismatch;
    logic hdr_last;
    logic rd_more;
    logic wr_more;
    logic push_ok;
  } sts_t;

  // One byte of the reflected Modbus CRC-16.
  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

>>> rtl/mbrs_ctrl.sv
// Sequencer for framing, checking, executing and answering requests.
module mbrs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rx_valid_i,
  output logic          rx_ready_o,
  input  mbrs_pkg::sts_t sts_i,
  output mbrs_pkg::cmd_t cmd_o
);

  typedef enum logic [16:0] {
    ST_CLEAR = 17'h00001,
    ST_IDLE  = 17'h00002,
    ST_CHECK = 17'h00004,
    ST_FN    = 17'h00008,
    ST_B6    = 17'h00010,
    ST_LEN   = 17'h00020,
    ST_CRC   = 17'h00040,
    ST_GOOD  = 17'h00080,
    ST_WREQ  = 17'h00100,
    ST_WHI   = 17'h00200,
    ST_WLO   = 17'h00400,
    ST_HDR   = 17'h00800,
    ST_RREQ  = 17'h01000,
    ST_RHI   = 17'h02000,
    ST_RLO   = 17'h04000,
    ST_CRCL  = 17'h08000,
    ST_CRCH  = 17'h10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign rx_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rsel = mbrs_pkg::RS_ZERO;
    cmd_o.psrc = mbrs_pkg::PS_HDR;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (rx_valid_i) begin
          cmd_o.append = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.fill_le4) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rsel  = mbrs_pkg::RS_FN;
          state_d = ST_FN;
        end
      end
      ST_FN: begin
        if (sts_i.fn_fixed) begin
          cmd_o.set_need8 = 1'b1;
          state_d = ST_LEN;
        end else if (sts_i.fn_multi) begin
          if (sts_i.fill_lt7) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.rd_en = 1'b1;
            cmd_o.rsel  = mbrs_pkg::RS_B6;
            state_d = ST_B6;
          end
        end else begin
          cmd_o.drop1 = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_B6: begin
        if (sts_i.need_big) begin
          cmd_o.drop1 = 1'b1;
          state_d = ST_CHECK;
        end else begin
          cmd_o.lat_need = 1'b1;
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (sts_i.fill_lt_need) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.crc_init = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rsel     = mbrs_pkg::RS_ZERO;
          state_d = ST_CRC;
        end
      end
      ST_CRC: begin
        cmd_o.crc_step = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rsel     = mbrs_pkg::RS_NEXT;
        if (sts_i.crc_last) begin
          if (sts_i.crc_good) begin
            state_d = ST_GOOD;
          end else begin
            cmd_o.drop_need = 1'b1;
            state_d = ST_CHECK;
          end
        end
      end
      ST_GOOD: begin
        cmd_o.rsp_init = 1'b1;
        if (sts_i.is_read || sts_i.is_mismatch) begin
          state_d = ST_HDR;
        end else if (sts_i.is_write1) begin
          cmd_o.wr_one = 1'b1;
          state_d = ST_HDR;
        end else begin
          state_d = ST_WREQ;
        end
      end
      ST_WREQ: begin
        if (sts_i.wr_more) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rsel  = mbrs_pkg::RS_WHI;
          state_d = ST_WHI;
        end else begin
          state_d = ST_HDR;
        end
      end
      ST_WHI: begin
        cmd_o.lat_hi = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rsel   = mbrs_pkg::RS_WLO;
        state_d = ST_WLO;
      end
      ST_WLO: begin
        cmd_o.wr_multi = 1'b1;
        cmd_o.i_inc    = 1'b1;
        state_d = ST_WREQ;
      end
      ST_HDR: begin
        if (sts_i.push_ok) begin
          cmd_o.push = 1'b1;
          cmd_o.psrc = mbrs_pkg::PS_HDR;
          if (sts_i.hdr_last) state_d = sts_i.is_read ? ST_RREQ : ST_CRCL;
        end
      end
      ST_RREQ: begin
        if (sts_i.rd_more) begin
          cmd_o.reg_rd = 1'b1;
          state_d = ST_RHI;
        end else begin
          state_d = ST_CRCL;
        end
      end
      ST_RHI: begin
        if (sts_i.push_ok) begin
          cmd_o.push = 1'b1;
          cmd_o.psrc = mbrs_pkg::PS_RHI;
          state_d = ST_RLO;
        end
      end
      ST_RLO: begin
        if (sts_i.push_ok) begin
          cmd_o.push  = 1'b1;
          cmd_o.psrc  = mbrs_pkg::PS_RLO;
          cmd_o.i_inc = 1'b1;
          state_d = ST_RREQ;
        end
      end
      ST_CRCL: begin
        if (sts_i.push_ok) begin
          cmd_o.push = 1'b1;
          cmd_o.psrc = mbrs_pkg::PS_CRCL;
          state_d = ST_CRCH;
        end
      end
      ST_CRCH: begin
        if (sts_i.push_ok) begin
          cmd_o.push      = 1'b1;
          cmd_o.psrc      = mbrs_pkg::PS_CRCH;
          cmd_o.drop_need = 1'b1;
          state_d = ST_CHECK;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

>>> rtl/mbrs_dp.sv
// Frame ring, register file, CRC units and beat assembler.
module mbrs_dp #(
  parameter int unsigned REG_DEPTH      = mbrs_pkg::REG_DEPTH_DEF,
  parameter int unsigned FRAME_BYTES    = mbrs_pkg::FRAME_BYTES_DEF,
  parameter int unsigned MAX_READ_COUNT = mbrs_pkg::MAX_READ_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     rx_byte_i,
  input  logic [7:0]     slave_addr_i,
  input  mbrs_pkg::cmd_t cmd_i,
  output mbrs_pkg::sts_t sts_o,
  output logic           tx_valid_o,
  input  logic           tx_ready_i,
  output logic [7:0]     tx_byte0_o,
  output logic [7:0]     tx_byte1_o,
  output logic [7:0]     tx_byte2_o,
  output logic [7:0]     tx_byte3_o,
  output logic [2:0]     beat_bytes_o,
  output logic           frame_last_o
);

  localparam int unsigned AW    = $clog2(FRAME_BYTES);
  localparam int unsigned RAW   = $clog2(REG_DEPTH);
  localparam int unsigned OFF_W = mbrs_pkg::OFF_W;
  localparam int unsigned CNT_W = mbrs_pkg::CNT_W;

  // Ring position of head plus offset, wrapped once.
  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] h, logic [OFF_W-1:0] o);
    logic [OFF_W:0] s;
    s = (OFF_W+1)'(h) + (OFF_W+1)'(o);
    if (s >= (OFF_W+1)'(FRAME_BYTES)) s = s - (OFF_W+1)'(FRAME_BYTES);
    return s[AW-1:0];
  endfunction

  function automatic logic in_range(logic [15:0] a);
    return 17'(a) < 17'(REG_DEPTH);
  endfunction

  logic [7:0]       store_mem [FRAME_BYTES];
  logic [15:0]      reg_mem   [REG_DEPTH];
  logic [AW-1:0]    head_q, head_d;
  logic [OFF_W-1:0] fill_q, fill_d;
  logic [OFF_W-1:0] need_q, pos_q;
  logic [7:0]       srd_q, hi_q;
  logic [15:0]      crc_q, rcrc_q, rrd_q;
  logic             lo_ok_q, rinr_q;
  logic [7:0]       f_q [7];
  logic [7:0]       i_q;
  logic [RAW-1:0]   clr_q;

  logic [OFF_W-1:0] roff;
  logic [AW-1:0]    raddr;
  logic [OFF_W:0]   need_b6;
  logic [15:0]      start_w, val_w, addr_i;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       cnt2;
  logic [OFF_W-1:0] hdr_len;
  logic [7:0]       hdr_byte, push_byte;
  logic             push_last;

  logic [7:0]       abuf_q [3];
  logic [1:0]       acnt_q;
  logic [7:0]       ob_q [4];
  logic [2:0]       bb_q;
  logic             fl_q, ov_q;

  assign start_w = {f_q[2], f_q[3]};
  assign val_w   = {f_q[4], f_q[5]};
  assign addr_i  = start_w + {8'h00, i_q};
  assign cnt     = (val_w > 16'(MAX_READ_COUNT)) ? CNT_W'(MAX_READ_COUNT) : val_w[CNT_W-1:0];
  assign cnt2    = {cnt, 1'b0};
  assign need_b6 = (OFF_W+1)'(mbrs_pkg::NEED_BASE) + (OFF_W+1)'(srd_q);

  always_comb begin
    case (cmd_i.rsel)
      mbrs_pkg::RS_FN:   roff = mbrs_pkg::OFF_FN;
      mbrs_pkg::RS_B6:   roff = mbrs_pkg::OFF_CNT;
      mbrs_pkg::RS_NEXT: roff = pos_q + OFF_W'(1);
      mbrs_pkg::RS_WHI:  roff = mbrs_pkg::OFF_DATA + OFF_W'({i_q, 1'b0});
      mbrs_pkg::RS_WLO:  roff = mbrs_pkg::OFF_DATA + OFF_W'({i_q, 1'b1});
      default:           roff = '0;
    endcase
  end
  assign raddr = ring_add(head_q, roff);

  // Frame ring: append at the tail, read at head plus offset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && (fill_q < OFF_W'(FRAME_BYTES))) begin
      store_mem[ring_add(head_q, fill_q)] <= rx_byte_i;
    end
    if (cmd_i.rd_en) srd_q <= store_mem[raddr];
  end

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (cmd_i.append && (fill_q < OFF_W'(FRAME_BYTES))) begin
      fill_d = fill_q + OFF_W'(1);
    end else if (cmd_i.drop1) begin
      head_d = ring_add(head_q, OFF_W'(1));
      fill_d = fill_q - OFF_W'(1);
    end else if (cmd_i.drop_need) begin
      head_d = ring_add(head_q, need_q);
      fill_d = fill_q - need_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      clr_q  <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      if (cmd_i.clr) clr_q <= clr_q + RAW'(1);
    end
  end

  // Request walk: CRC, header capture, write loop and response counters.
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_need8) need_q <= mbrs_pkg::NEED_FIXED;
    if (cmd_i.lat_need)  need_q <= need_b6[OFF_W-1:0];
    if (cmd_i.lat_hi)    hi_q   <= srd_q;
    if (cmd_i.crc_init) begin
      crc_q <= mbrs_pkg::CRC_INIT;
      pos_q <= '0;
    end else if (cmd_i.crc_step) begin
      if (pos_q < need_q - OFF_W'(2)) begin
        crc_q <= mbrs_pkg::crc_byte(crc_q, srd_q);
        if (pos_q < OFF_W'(7)) f_q[pos_q[2:0]] <= srd_q;
      end else if (pos_q == need_q - OFF_W'(2)) begin
        lo_ok_q <= (srd_q == crc_q[7:0]);
      end
      pos_q <= pos_q + OFF_W'(1);
    end else if (cmd_i.rsp_init) begin
      pos_q <= '0;
    end else if (cmd_i.push && (cmd_i.psrc == mbrs_pkg::PS_HDR)) begin
      pos_q <= pos_q + OFF_W'(1);
    end
    if (cmd_i.rsp_init) begin
      rcrc_q <= mbrs_pkg::CRC_INIT;
      i_q    <= '0;
    end else begin
      if (cmd_i.i_inc) i_q <= i_q + 8'd1;
      if (cmd_i.push && (cmd_i.psrc != mbrs_pkg::PS_CRCL)
          && (cmd_i.psrc != mbrs_pkg::PS_CRCH)) begin
        rcrc_q <= mbrs_pkg::crc_byte(rcrc_q, push_byte);
      end
    end
  end

  // Register file: clearing pass, single writes, loop writes and reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      reg_mem[clr_q] <= '0;
    end else if (cmd_i.wr_one && in_range(start_w)) begin
      reg_mem[start_w[RAW-1:0]] <= val_w;
    end else if (cmd_i.wr_multi && in_range(addr_i)) begin
      reg_mem[addr_i[RAW-1:0]] <= {hi_q, srd_q};
    end
    if (cmd_i.reg_rd) begin
      rrd_q  <= reg_mem[addr_i[RAW-1:0]];
      rinr_q <= in_range(addr_i);
    end
  end

  assign hdr_len = (sts_o.is_read || sts_o.is_mismatch) ? mbrs_pkg::HDR_SHORT
                                                        : mbrs_pkg::HDR_ECHO;

  always_comb begin
    hdr_byte = f_q[0];
    if (sts_o.is_read) begin
      case (pos_q[1:0])
        2'd1:    hdr_byte = mbrs_pkg::FN_READ;
        2'd2:    hdr_byte = cnt2;
        default: hdr_byte = f_q[0];
      endcase
    end else if (sts_o.is_mismatch) begin
      case (pos_q[1:0])
        2'd1:    hdr_byte = f_q[1] + mbrs_pkg::EXC_FLAG;
        2'd2:    hdr_byte = mbrs_pkg::EXC_ADDR;
        default: hdr_byte = f_q[0];
      endcase
    end else if (pos_q < OFF_W'(6)) begin
      hdr_byte = f_q[pos_q[2:0]];
    end
  end

  always_comb begin
    case (cmd_i.psrc)
      mbrs_pkg::PS_RHI:  push_byte = rinr_q ? rrd_q[15:8] : 8'h00;
      mbrs_pkg::PS_RLO:  push_byte = rinr_q ? rrd_q[7:0] : 8'h00;
      mbrs_pkg::PS_CRCL: push_byte = rcrc_q[7:0];
      mbrs_pkg::PS_CRCH: push_byte = rcrc_q[15:8];
      default:           push_byte = hdr_byte;
    endcase
  end
  assign push_last = (cmd_i.psrc == mbrs_pkg::PS_CRCH);

  // Beat assembler and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acnt_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (tx_ready_i) ov_q <= 1'b0;
      if (cmd_i.push) begin
        if ((acnt_q == 2'd3) || push_last) begin
          acnt_q <= '0;
          ov_q   <= 1'b1;
        end else begin
          acnt_q <= acnt_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      if ((acnt_q == 2'd3) || push_last) begin
        for (int k = 0; k < 3; k++) begin
          if (k < int'(acnt_q)) ob_q[k] <= abuf_q[k];
          else if (k == int'(acnt_q)) ob_q[k] <= push_byte;
          else ob_q[k] <= 8'h00;
        end
        ob_q[3] <= (acnt_q == 2'd3) ? push_byte : 8'h00;
        bb_q <= 3'(acnt_q) + 3'd1;
        fl_q <= push_last;
      end else begin
        abuf_q[acnt_q] <= push_byte;
      end
    end
  end

  assign tx_valid_o   = ov_q;
  assign tx_byte0_o   = ob_q[0];
  assign tx_byte1_o   = ob_q[1];
  assign tx_byte2_o   = ob_q[2];
  assign tx_byte3_o   = ob_q[3];
  assign beat_bytes_o = bb_q;
  assign frame_last_o = fl_q;

  always_comb begin
    sts_o              = '0;
    sts_o.clr_done     = (clr_q == RAW'(REG_DEPTH - 1));
    sts_o.fill_le4     = (fill_q <= mbrs_pkg::FILL_MIN);
    sts_o.fill_lt7     = (fill_q < mbrs_pkg::FILL_MULTI);
    sts_o.fn_fixed     = (srd_q == mbrs_pkg::FN_READ) || (srd_q == mbrs_pkg::FN_WRITE1);
    sts_o.fn_multi     = (srd_q == mbrs_pkg::FN_WRITEN);
    sts_o.need_big     = (need_b6 > (OFF_W+1)'(FRAME_BYTES));
    sts_o.fill_lt_need = (fill_q < need_q);
    sts_o.crc_last     = (pos_q == need_q - OFF_W'(1));
    sts_o.crc_good     = lo_ok_q && (srd_q == crc_q[15:8]);
    sts_o.is_read      = (f_q[1] == mbrs_pkg::FN_READ);
    sts_o.is_write1    = (f_q[1] == mbrs_pkg::FN_WRITE1);
    sts_o.is_mismatch  = (f_q[1] != mbrs_pkg::FN_READ) && (f_q[0] != slave_addr_i);
    sts_o.hdr_last     = (pos_q == hdr_len - OFF_W'(1));
    sts_o.rd_more      = ({1'b0, i_q} < 9'(cnt));
    sts_o.wr_more      = ({8'h00, i_q} < val_w) && ({i_q, 1'b1} < {1'b0, f_q[6]});
    sts_o.push_ok      = !ov_q || tx_ready_i;
  end

endmodule

>>> rtl/modbus_rtu_slave_register_map.sv
// Top level of the Modbus RTU slave register map: APB register and core wiring.
//
// Usage: received serial bytes enter one byte at a time on the rx channel
// (rx_valid_i/rx_ready_o, rx_byte_i). The block collects them in a frame ring,
// finds function 0x03, 0x06 and 0x10 requests, checks the CRC-16 (low byte
// first), executes them against a 16-bit register file and sends the reply on
// the tx channel as words of up to four bytes (tx_byte0_o..tx_byte3_o,
// beat_bytes_o, frame_last_o on the final word of a reply).
// Unknown function codes and oversize write-several frames drop one leading
// byte to resync. slave_address (APB byte address 0, reset 1) is compared on
// write requests only; a mismatch yields exception 3.
// Flow: rx_ready_o is high only while the sequencer is idle; a byte that
// completes no frame keeps it low while the ring is checked, longer for each
// leading byte dropped. A completed frame walks the ring once for its CRC and
// passes the write states once per register written by function 0x10; header
// and CRC bytes then go out one per cycle unless stalled, read data in between.
// Reset: control state clears at once, then a clearing pass zeroes the
// register file entry by entry while rx_ready_o stays low; APB writes
// are taken throughout.
// Stall: a finished word waits in the output register; the core holds its next
// reply byte until tx_ready_i frees that register, and nothing is dropped.
module modbus_rtu_slave_register_map #(
  parameter int unsigned REG_DEPTH      = mbrs_pkg::REG_DEPTH_DEF,
  parameter int unsigned FRAME_BYTES    = mbrs_pkg::FRAME_BYTES_DEF,
  parameter int unsigned MAX_READ_COUNT = mbrs_pkg::MAX_READ_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        tx_valid_o,
  input  logic        tx_ready_i,
  output logic [7:0]  tx_byte0_o,
  output logic [7:0]  tx_byte1_o,
  output logic [7:0]  tx_byte2_o,
  output logic [7:0]  tx_byte3_o,
  output logic [2:0]  beat_bytes_o,
  output logic        frame_last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]     slave_addr_q;
  mbrs_pkg::cmd_t cmd;
  mbrs_pkg::sts_t sts;

  // Single register at byte address 0; higher word addresses read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'd1;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      slave_addr_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'h0 : {24'h0, slave_addr_q};

  mbrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mbrs_dp #(
    .REG_DEPTH      (REG_DEPTH),
    .FRAME_BYTES    (FRAME_BYTES),
    .MAX_READ_COUNT (MAX_READ_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .slave_addr_i (slave_addr_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .tx_valid_o   (tx_valid_o),
    .tx_ready_i   (tx_ready_i),
    .tx_byte0_o   (tx_byte0_o),
    .tx_byte1_o   (tx_byte1_o),
    .tx_byte2_o   (tx_byte2_o),
    .tx_byte3_o   (tx_byte3_o),
    .beat_bytes_o (beat_bytes_o),
    .frame_last_o (frame_last_o)
  );

endmodule

>>> rtl/mbrs_checker.sv
// Port-level checks for the Modbus RTU slave register map.
module mbrs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       tx_valid_o,
  input logic       tx_ready_i,
  input logic [7:0] tx_byte1_o,
  input logic [7:0] tx_byte2_o,
  input logic [7:0] tx_byte3_o,
  input logic [2:0] beat_bytes_o,
  input logic       frame_last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o && !tx_ready_i |=> tx_valid_o && $stable(beat_bytes_o)
      && $stable(frame_last_o))
    else $error("tx word changed while stalled");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o |-> (beat_bytes_o != 3'd0) && (beat_bytes_o <= 3'd4))
    else $error("tx word byte count out of range");

  a_short_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o && (beat_bytes_o != 3'd4) |-> frame_last_o)
    else $error("short tx word before end of reply");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o && (beat_bytes_o == 3'd1) |->
      (tx_byte1_o == 8'h00) && (tx_byte2_o == 8'h00) && (tx_byte3_o == 8'h00))
    else $error("unused tx bytes not zero");

endmodule

bind modbus_rtu_slave_register_map mbrs_checker u_mbrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tx_valid_o   (tx_valid_o),
  .tx_ready_i   (tx_ready_i),
  .tx_byte1_o   (tx_byte1_o),
  .tx_byte2_o   (tx_byte2_o),
  .tx_byte3_o   (tx_byte3_o),
  .beat_bytes_o (beat_bytes_o),
  .frame_last_o (frame_last_o)
);

>>> tb/sv/modbus_rtu_slave_register_map_test.sv
// Self-checking testbench for the Modbus RTU slave register map.
module modbus_rtu_slave_register_map_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REG_N   = 1024;
  localparam int unsigned STORE_N = 256;
  localparam int unsigned RD_MAX  = 125;
  localparam logic [2:0] ADDR_SLAVE = 3'd0;

  // One response word as the block presents it.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] nbytes;
    logic       last;
  } tx_word_t;

  // Scoreboard: keeps its own copy of the slave state and the expected words.
  class modbus_scoreboard;
    logic [7:0]  own_addr;
    logic [7:0]  store [STORE_N];
    int unsigned fill;
    logic [15:0] regs [REG_N];
    tx_word_t    pending_words [$];
    int          errors;

    function new();
      own_addr = 8'd1;
      fill = 0;
      errors = 0;
      foreach (regs[i]) regs[i] = '0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function logic [15:0] crc_of(logic [7:0] buf_q [$]);
      logic [15:0] c;
      c = 16'hFFFF;
      foreach (buf_q[i]) begin
        c ^= {8'h00, buf_q[i]};
        for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
    endfunction

    function void shift_out(int unsigned n);
      if (n > fill) n = fill;
      for (int i = 0; i + n < fill; i++) store[i] = store[i + n];
      fill -= n;
    endfunction

    // Append CRC and split the reply into words of up to four bytes.
    function void queue_reply(logic [7:0] rsp [$]);
      logic [15:0] c;
      tx_word_t w;
      int n;
      c = crc_of(rsp);
      rsp.push_back(c[7:0]);
      rsp.push_back(c[15:8]);
      for (int off = 0; off < rsp.size(); off += 4) begin
        n = rsp.size() - off;
        if (n > 4) n = 4;
        w.b0 = rsp[off];
        w.b1 = (n > 1) ? rsp[off + 1] : 8'h00;
        w.b2 = (n > 2) ? rsp[off + 2] : 8'h00;
        w.b3 = (n > 3) ? rsp[off + 3] : 8'h00;
        w.nbytes = n[2:0];
        w.last = (off + 4 >= rsp.size());
        pending_words.push_back(w);
      end
    endfunction

    function void execute(int unsigned len);
      logic [7:0] rsp [$];
      logic [7:0] fn;
      logic [15:0] start, val, v, a;
      int unsigned cnt;
      fn = store[1];
      start = {store[2], store[3]};
      val = {store[4], store[5]};
      if (fn == mbrs_pkg::FN_READ) begin
        cnt = (val > RD_MAX) ? RD_MAX : val;
        rsp = '{store[0], mbrs_pkg::FN_READ, 8'(cnt * 2)};
        for (int i = 0; i < cnt; i++) begin
          a = start + 16'(i);
          v = (a < REG_N) ? regs[a] : 16'h0;
          rsp.push_back(v[15:8]);
          rsp.push_back(v[7:0]);
        end
      end else if (store[0] != own_addr) begin
        rsp = '{store[0], fn + mbrs_pkg::EXC_FLAG, mbrs_pkg::EXC_ADDR};
      end else begin
        if (fn == mbrs_pkg::FN_WRITE1) begin
          if (start < REG_N) regs[start] = val;
        end else begin
          for (int i = 0; i < val && 2 * i + 1 < store[6] && 8 + 2 * i < len; i++) begin
            a = start + 16'(i);
            if (a < REG_N) regs[a] = {store[7 + 2 * i], store[8 + 2 * i]};
          end
        end
        for (int i = 0; i < 6; i++) rsp.push_back(store[i]);
      end
      queue_reply(rsp);
    endfunction

    // Note one accepted byte and predict any words it releases.
    function void note_byte(logic [7:0] b);
      int unsigned need;
      logic [7:0] body [$];
      logic [15:0] c;
      if (fill < STORE_N) begin
        store[fill] = b;
        fill++;
      end
      while (fill > 4) begin
        if (store[1] == mbrs_pkg::FN_READ || store[1] == mbrs_pkg::FN_WRITE1) need = 8;
        else if (store[1] == mbrs_pkg::FN_WRITEN) begin
          if (fill < 7) break;
          need = 9 + store[6];
          if (need > STORE_N) begin
            shift_out(1);
            continue;
          end
        end else begin
          shift_out(1);
          continue;
        end
        if (fill < need) break;
        body.delete();
        for (int i = 0; i < need - 2; i++) body.push_back(store[i]);
        c = crc_of(body);
        if (store[need - 2] == c[7:0] && store[need - 1] == c[15:8]) execute(need);
        shift_out(need);
      end
    endfunction

    function void check_word(tx_word_t got);
      tx_word_t exp;
      if (pending_words.size() == 0) begin
        $error("unexpected word %p", got);
        errors++;
        return;
      end
      exp = pending_words.pop_front();
      if (got.b0 != exp.b0) begin $error("tx_byte0 exp %h got %h", exp.b0, got.b0); errors++; end
      if (got.b1 != exp.b1) begin $error("tx_byte1 exp %h got %h", exp.b1, got.b1); errors++; end
      if (got.b2 != exp.b2) begin $error("tx_byte2 exp %h got %h", exp.b2, got.b2); errors++; end
      if (got.b3 != exp.b3) begin $error("tx_byte3 exp %h got %h", exp.b3, got.b3); errors++; end
      if (got.nbytes != exp.nbytes) begin
        $error("beat_bytes exp %0d got %0d", exp.nbytes, got.nbytes);
        errors++;
      end
      if (got.last != exp.last) begin
        $error("frame_last exp %0d got %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic rx_valid_i, rx_ready_o;
  logic [7:0] rx_byte_i;
  logic tx_valid_o, tx_ready_i;
  logic [7:0] tx_byte0_o, tx_byte1_o, tx_byte2_o, tx_byte3_o;
  logic [2:0] beat_bytes_o;
  logic frame_last_o;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  modbus_scoreboard sb;
  bit tx_no_stall;  // hold tx_ready high during the calm stretch

  modbus_rtu_slave_register_map uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Sink: stall at random, check every accepted word.
  always @(posedge clk_i) begin
    if (rst_ni && tx_valid_o && tx_ready_i)
      sb.check_word('{tx_byte0_o, tx_byte1_o, tx_byte2_o, tx_byte3_o, beat_bytes_o, frame_last_o});
    tx_ready_i <= tx_no_stall || ($urandom_range(99) >= 8);
  end

  // Send one byte; valid stays high until taken and drops only on an idle cycle.
  task automatic send_byte(logic [7:0] b, bit calm);
    while (!calm && $urandom_range(99) < 8) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    sb.note_byte(b);
  endtask

  task automatic send_frame(logic [7:0] body [$], bit good_crc, bit calm);
    logic [15:0] c;
    c = sb.crc_of(body);
    if (!good_crc) c ^= 16'(1 << $urandom_range(15));
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    foreach (body[i]) send_byte(body[i], calm);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drop valid and hold the sender until every expected word is in.
  task automatic wait_replies();
    rx_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_words.size() != 0);
  endtask

  // Wait until every expected word is in, then let the core settle.
  task automatic drain();
    wait_replies();
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_slave(logic [7:0] a);
    drain();
    apb_write(ADDR_SLAVE, {24'h0, a});
    sb.own_addr = a;
  endtask

  // Build a random request, mostly well-formed, aimed mostly at low registers.
  task automatic random_request(bit calm);
    logic [7:0] f [$];
    logic [15:0] start, cnt;
    int kind, nb;
    kind = $urandom_range(2);
    start = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    f.push_back(($urandom_range(4) == 0) ? 8'($urandom) : sb.own_addr);
    if (kind == 0) begin
      cnt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12));
      f = {f, mbrs_pkg::FN_READ, start[15:8], start[7:0], cnt[15:8], cnt[7:0]};
    end else if (kind == 1) begin
      cnt = 16'($urandom);
      f = {f, mbrs_pkg::FN_WRITE1, start[15:8], start[7:0], cnt[15:8], cnt[7:0]};
    end else begin
      cnt = 16'($urandom_range(6));
      nb = ($urandom_range(5) == 0) ? $urandom_range(14) : 2 * cnt;
      f = {f, mbrs_pkg::FN_WRITEN, start[15:8], start[7:0], cnt[15:8], cnt[7:0], 8'(nb)};
      for (int i = 0; i < nb; i++) f.push_back(8'($urandom));
    end
    send_frame(f, $urandom_range(9) != 0, calm);
  endtask

  initial begin
    logic [7:0] d [$];
    sb = new();
    rst_ni = 1'b0;
    rx_valid_i = 1'b0; rx_byte_i = '0; tx_ready_i = 1'b0; tx_no_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: each function, extremes, special cases.
    send_frame('{8'h01, mbrs_pkg::FN_WRITE1, 8'h00, 8'h00, 8'hFF, 8'hFF}, 1, 0);
    send_frame('{8'h01, mbrs_pkg::FN_WRITE1, 8'h03, 8'hFF, 8'hA5, 8'h5A}, 1, 0);
    // out of range
    send_frame('{8'h01, mbrs_pkg::FN_WRITE1, 8'hFF, 8'hFF, 8'h12, 8'h34}, 1, 0);
    send_frame('{8'h01, mbrs_pkg::FN_READ, 8'h03, 8'hFE, 8'h00, 8'h03}, 1, 0);
    // wrap past 65535
    send_frame('{8'h01, mbrs_pkg::FN_READ, 8'hFF, 8'hFF, 8'h00, 8'h03}, 1, 0);
    // zero count
    send_frame('{8'hFF, mbrs_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h00}, 1, 0);
    // saturates
    send_frame('{8'h00, mbrs_pkg::FN_READ, 8'h00, 8'h00, 8'hFF, 8'hFF}, 1, 0);
    // mismatch
    send_frame('{8'h07, mbrs_pkg::FN_WRITE1, 8'h00, 8'h01, 8'h00, 8'h01}, 1, 0);
    send_frame('{8'h07, mbrs_pkg::FN_WRITEN, 8'h00, 8'h01, 8'h00, 8'h01, 8'h02,
                 8'h11, 8'h22}, 1, 0);
    send_frame('{8'h01, mbrs_pkg::FN_WRITEN, 8'h00, 8'h08, 8'h00, 8'h05, 8'h03,
                 8'hDE, 8'hAD, 8'hBE}, 1, 0);
    // bad CRC
    send_frame('{8'h01, mbrs_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h0A}, 0, 0);
    send_byte(8'h55, 0); send_byte(8'h00, 0);                          // unknown function
    // oversize frame
    d = '{8'h01, mbrs_pkg::FN_WRITEN, 8'h00, 8'h00, 8'h00, 8'h01, 8'hF8};
    foreach (d[i]) send_byte(d[i], 0);
    send_frame('{8'h01, mbrs_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h0C}, 1, 0);

    set_slave(8'h00);
    send_frame('{8'h00, mbrs_pkg::FN_WRITE1, 8'h00, 8'h02, 8'h80, 8'h01}, 1, 0);
    set_slave(8'hFF);
    send_frame('{8'hFF, mbrs_pkg::FN_WRITE1, 8'h00, 8'h04, 8'h7F, 8'hFE}, 1, 0);

    // Random: phases with different addresses, one calm stretch, one full pause.
    for (int ph = 0; ph < 4; ph++) begin
      set_slave(ph == 3 ? 8'($urandom) : 8'($urandom_range(255)));
      tx_no_stall = (ph == 1);
      for (int n = 0; n < 2; n++) begin
        if ($urandom_range(7) == 0) send_byte(8'($urandom), ph == 1);
        random_request(ph == 1);
        if (ph == 2 && n == 0) wait_replies();
      end
    end
    tx_no_stall = 1'b0;
    drain();

    if (sb.errors == 0) $display("modbus_rtu_slave_register_map_test: done, clean");
    else $display("modbus_rtu_slave_register_map_test: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("modbus_rtu_slave_register_map_test: done, errors");
    $finish;
  end
endmodule
